// ===== hw/rtl/sse_pkg.sv =====
// sse_pkg: shared types and constants for the snapshot spacing evictor.
// No dependencies.
package sse_pkg;
    localparam int TableDepth = 512;
    localparam int FrameBits  = 24;
    localparam int AddrBits   = $clog2(TableDepth);
    localparam int CountBits  = AddrBits + 1;
    localparam logic [31:0] LcgMul = 32'd22695477;
    localparam logic [14:0] DrawMask = 15'h7fff;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EVICTED  = 3'd3;
    localparam logic [2:0] ST_TOO_FEW  = 3'd4;

    localparam logic [0:0] CFG_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_SEED      = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [FrameBits-1:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [FrameBits-1:0] evicted_frame;
        logic [8:0]           evicted_position;
    } t_out_item;

    typedef struct packed {
        logic [0:0]  index;
        logic [31:0] data;
    } t_cfg_beat;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_INS_RD, S_INS_WR,
        S_LCG, S_DIV, S_SCR_RDI, S_SCR_LATI, S_SCR_RDJ, S_SCR_SQ, S_SCR_ACC,
        S_SCR_END, S_EV_RD, S_EV_LAT, S_SH_RD, S_SH_WR, S_OUT
    } t_state;
endpackage

// ===== hw/rtl/snapshot_spacing_evictor_top.sv =====
// snapshot_spacing_evictor_top: sorted checkpoint table with spacing-based eviction.
// Depends on sse_pkg.
//
// Usage: input beats (kind, frame_number) on i_in_valid/o_in_ready, one result
// beat (status, evicted_frame, evicted_position) on o_out_valid/i_out_ready,
// config beats (index, data) on i_cfg_valid/o_cfg_ready. One item is in flight
// at a time; o_in_ready is low from accept until the result beat is taken.
// Flow: an insert walks the table through one RAM with one read and one write
// port: it searches for its place, then shifts the entries above it up; an
// eviction by random draw takes the LCG step, the 15-step restoring division
// and the victim read, then closes the gap; an eviction by spacing scores
// every interior pair through one 25x25 multiplier, then closes the gap.
// Reset clears the count, loads threshold 300 and seed 1; the table needs no
// clearing pass. A stalled receiver holds the result register and the block
// takes no new item until the beat leaves. Config is taken at any time but
// is meant for idle periods; a seed write reloads the generator at once.
module snapshot_spacing_evictor_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sse_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  sse_pkg::t_cfg_beat i_cfg_data
);
    localparam int AW = sse_pkg::AddrBits;
    localparam int CW = sse_pkg::CountBits;
    localparam int FW = sse_pkg::FrameBits;

    // table memory
    logic [FW-1:0] r_mem [sse_pkg::TableDepth];
    logic [FW-1:0] r_rd;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [FW-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    sse_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [9:0]    r_thr;
    logic [31:0]   r_lcg, n_lcg;
    logic [FW-1:0] r_key, n_key;       // insert frame
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_pos, n_pos;
    logic [FW-1:0] r_fi, n_fi;
    logic [FW:0]   r_d, n_d;
    logic [63:0]   r_acc, n_acc, r_best, n_best;
    logic [14:0]   r_rem, n_rem;       // division remainder
    logic [14:0]   r_dvd, n_dvd;
    logic [3:0]    r_bit, n_bit;
    logic          r_ovalid, n_ovalid;
    sse_pkg::t_out_item r_out, n_out;

    assign o_in_ready  = (r_state == sse_pkg::S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 10'd300;
        end else if (i_cfg_valid && i_cfg_data.index == sse_pkg::CFG_THRESHOLD) begin
            r_thr <= i_cfg_data.data[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sse_pkg::S_IDLE;
            r_count  <= '0;
            r_lcg    <= 32'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_lcg    <= (i_cfg_valid && i_cfg_data.index == sse_pkg::CFG_SEED)
                        ? i_cfg_data.data : n_lcg;
            r_ovalid <= n_ovalid;
        end
        r_key <= n_key; r_i <= n_i; r_j <= n_j; r_pos <= n_pos;
        r_fi <= n_fi; r_d <= n_d; r_acc <= n_acc;
        r_best <= n_best; r_rem <= n_rem; r_dvd <= n_dvd; r_bit <= n_bit;
        r_out <= n_out;
    end

    logic [CW-1:0] w_last;             // count-1: last index
    logic [CW-1:0] w_div;              // count-2
    logic [15:0]   w_trial;
    logic [FW:0]   w_diff;
    assign w_last  = r_count - CW'(1);
    assign w_div   = r_count - CW'(2);
    assign w_trial = {r_rem, r_dvd[14]};
    assign w_diff  = {1'b0, r_rd} - {1'b0, r_fi};

    // sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_lcg = r_lcg;
        n_key = r_key; n_i = r_i; n_j = r_j; n_pos = r_pos; n_fi = r_fi;
        n_d = r_d; n_acc = r_acc; n_best = r_best;
        n_rem = r_rem; n_dvd = r_dvd; n_bit = r_bit;
        n_ovalid = r_ovalid; n_out = r_out;
        w_we = 1'b0; w_waddr = r_pos[AW-1:0]; w_wdata = r_key;
        w_raddr = r_pos[AW-1:0];
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            sse_pkg::S_IDLE: begin
                if (i_in_valid && !r_ovalid) begin
                    n_key  = i_in_data.frame_number;
                    n_pos  = '0;
                    if (!i_in_data.kind) begin
                        n_state = sse_pkg::S_SRCH_RD;
                    end else if (r_count <= CW'(2)) begin
                        n_out   = '{sse_pkg::ST_TOO_FEW, '0, '0};
                        n_state = sse_pkg::S_OUT;
                    end else if (32'(r_thr) <= 32'(r_count)) begin
                        n_state = sse_pkg::S_LCG;
                    end else begin
                        n_i = CW'(1); n_best = '1; n_pos = CW'(1);
                        n_state = sse_pkg::S_SCR_RDI;
                    end
                end
            end
            // linear search for the insert place
            sse_pkg::S_SRCH_RD: begin
                if (r_pos >= r_count) begin
                    if (r_count >= CW'(sse_pkg::TableDepth)) begin
                        n_out = '{sse_pkg::ST_FULL, '0, '0};
                        n_state = sse_pkg::S_OUT;
                    end else begin
                        n_i = r_pos; n_j = r_count;
                        n_state = sse_pkg::S_INS_RD;
                    end
                end else begin
                    w_raddr = r_pos[AW-1:0];
                    n_state = sse_pkg::S_SRCH_CMP;
                end
            end
            sse_pkg::S_SRCH_CMP: begin
                if (r_rd == r_key) begin
                    n_out = '{sse_pkg::ST_PRESENT, '0, '0};
                    n_state = sse_pkg::S_OUT;
                end else if (r_rd > r_key) begin
                    if (r_count >= CW'(sse_pkg::TableDepth)) begin
                        n_out = '{sse_pkg::ST_FULL, '0, '0};
                        n_state = sse_pkg::S_OUT;
                    end else begin
                        n_i = r_pos; n_j = r_count;
                        n_state = sse_pkg::S_INS_RD;
                    end
                end else begin
                    n_pos = r_pos + CW'(1);
                    n_state = sse_pkg::S_SRCH_RD;
                end
            end
            // shift up from the top: r_j is the slot to fill
            sse_pkg::S_INS_RD: begin
                if (r_j == r_i) begin
                    w_we = 1'b1; w_waddr = r_i[AW-1:0]; w_wdata = r_key;
                    n_count = r_count + CW'(1);
                    n_out = '{sse_pkg::ST_INSERTED, '0, '0};
                    n_state = sse_pkg::S_OUT;
                end else begin
                    w_raddr = AW'(r_j - CW'(1));
                    n_state = sse_pkg::S_INS_WR;
                end
            end
            sse_pkg::S_INS_WR: begin
                w_we = 1'b1; w_waddr = r_j[AW-1:0]; w_wdata = r_rd;
                n_j = r_j - CW'(1);
                n_state = sse_pkg::S_INS_RD;
            end
            // random draw: one LCG step then restoring division
            sse_pkg::S_LCG: begin
                n_lcg = r_lcg * sse_pkg::LcgMul + 32'd1;
                n_dvd = n_lcg[30:16] & sse_pkg::DrawMask;
                n_rem = '0; n_bit = 4'd0;
                n_state = sse_pkg::S_DIV;
            end
            sse_pkg::S_DIV: begin
                if (w_trial >= 16'(w_div)) begin
                    n_rem = 15'(w_trial - 16'(w_div));
                end else begin
                    n_rem = w_trial[14:0];
                end
                n_dvd = {r_dvd[13:0], 1'b0};
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd14) begin
                    n_pos = CW'(n_rem) + CW'(1);
                    n_state = sse_pkg::S_EV_RD;
                end
            end
            // spacing score: outer i, inner j over interior entries
            sse_pkg::S_SCR_RDI: begin
                if (r_i >= w_last) begin
                    n_state = sse_pkg::S_EV_RD;
                end else begin
                    w_raddr = r_i[AW-1:0];
                    n_state = sse_pkg::S_SCR_LATI;
                end
            end
            sse_pkg::S_SCR_LATI: begin
                n_fi = r_rd; n_j = CW'(1); n_acc = '0;
                n_state = sse_pkg::S_SCR_RDJ;
            end
            sse_pkg::S_SCR_RDJ: begin
                if (r_j >= w_last) begin
                    n_state = sse_pkg::S_SCR_END;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    w_raddr = r_j[AW-1:0];
                    n_state = sse_pkg::S_SCR_SQ;
                end
            end
            sse_pkg::S_SCR_SQ: begin
                n_d = w_diff[FW] ? (~w_diff + (FW+1)'(1)) : w_diff;
                n_state = sse_pkg::S_SCR_ACC;
            end
            sse_pkg::S_SCR_ACC: begin
                n_acc = r_acc + 64'(r_d) * 64'(r_d);
                n_j = r_j + CW'(1);
                n_state = sse_pkg::S_SCR_RDJ;
            end
            sse_pkg::S_SCR_END: begin
                if (r_acc < r_best) begin
                    n_best = r_acc; n_pos = r_i;
                end
                n_i = r_i + CW'(1);
                n_state = sse_pkg::S_SCR_RDI;
            end
            // read the victim, then close the gap
            sse_pkg::S_EV_RD: begin
                w_raddr = r_pos[AW-1:0];
                n_state = sse_pkg::S_EV_LAT;
            end
            sse_pkg::S_EV_LAT: begin
                n_out = '{sse_pkg::ST_EVICTED, r_rd, 9'(r_pos)};
                n_j = r_pos;
                n_state = sse_pkg::S_SH_RD;
            end
            sse_pkg::S_SH_RD: begin
                if (r_j >= w_last) begin
                    n_count = r_count - CW'(1);
                    n_state = sse_pkg::S_OUT;
                end else begin
                    w_raddr = AW'(r_j + CW'(1));
                    n_state = sse_pkg::S_SH_WR;
                end
            end
            sse_pkg::S_SH_WR: begin
                w_we = 1'b1; w_waddr = r_j[AW-1:0]; w_wdata = r_rd;
                n_j = r_j + CW'(1);
                n_state = sse_pkg::S_SH_RD;
            end
            sse_pkg::S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_state = sse_pkg::S_IDLE;
                end
            end
            default: n_state = sse_pkg::S_IDLE;
        endcase
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sse_pkg::TableDepth))
        else $error("entry count over depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_out_ready |=> r_ovalid && $stable(r_out))
        else $error("result dropped while stalled");
    a_ev_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.status == sse_pkg::ST_EVICTED |->
        r_out.evicted_position != 9'd0)
        else $error("evicted an end entry");
endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for snapshot_spacing_evictor_top.
// Depends on sse_pkg and the RTL top; directed table, then random phases
// under several threshold/seed settings, checked against a local predictor.
`timescale 1ns / 100ps

module tb_top;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sse_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    sse_pkg::t_out_item o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    sse_pkg::t_cfg_beat i_cfg_data;

    snapshot_spacing_evictor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EVICT  = 1'b1;
    localparam logic [sse_pkg::FrameBits-1:0] FRAME_MAX = {sse_pkg::FrameBits{1'b1}};

    // Shadow copy of the block's table and registers
    logic [sse_pkg::FrameBits-1:0] shadow_keys [sse_pkg::TableDepth];
    int unsigned          shadow_count;
    logic [31:0]          shadow_lcg;
    logic [9:0]           shadow_thresh;

    sse_pkg::t_out_item result_q[$];
    int        err_count;
    bit        no_idle;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin
        #80_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Least summed squared spacing among interior entries, first on ties
    function automatic int unsigned spacing_victim();
        int unsigned    best_pos;
        longint unsigned least_cost;
        longint unsigned score;
        longint unsigned d;
        best_pos   = 1;
        least_cost = '1;
        for (int unsigned i = 1; i + 1 < shadow_count; i++) begin
            score = 0;
            for (int unsigned j = 1; j + 1 < shadow_count; j++) begin
                if (j == i) continue;
                d = (shadow_keys[j] > shadow_keys[i]) ? shadow_keys[j] - shadow_keys[i]
                                                      : shadow_keys[i] - shadow_keys[j];
                score += d * d;
            end
            if (score < least_cost) begin
                least_cost = score;
                best_pos   = i;
            end
        end
        return best_pos;
    endfunction

    // Apply one beat to the shadow table and return the result it causes
    function automatic sse_pkg::t_out_item evict_or_insert(input sse_pkg::t_in_item item);
        sse_pkg::t_out_item res;
        int unsigned pos;
        logic [14:0] draw;
        res = '0;
        if (item.kind == KIND_INSERT) begin
            pos = 0;
            while (pos < shadow_count && shadow_keys[pos] < item.frame_number) pos++;
            if (pos < shadow_count && shadow_keys[pos] == item.frame_number) begin
                res.status = sse_pkg::ST_PRESENT;
            end else if (shadow_count >= sse_pkg::TableDepth) begin
                res.status = sse_pkg::ST_FULL;
            end else begin
                for (int unsigned k = shadow_count; k > pos; k--)
                    shadow_keys[k] = shadow_keys[k-1];
                shadow_keys[pos] = item.frame_number;
                shadow_count++;
                res.status = sse_pkg::ST_INSERTED;
            end
        end else if (shadow_count <= 2) begin
            res.status = sse_pkg::ST_TOO_FEW;
        end else begin
            if (shadow_count >= shadow_thresh) begin
                shadow_lcg = shadow_lcg * sse_pkg::LcgMul + 32'd1;
                draw = shadow_lcg[30:16] & sse_pkg::DrawMask;
                pos  = 1 + draw % (shadow_count - 2);
            end else begin
                pos = spacing_victim();
            end
            res.status           = sse_pkg::ST_EVICTED;
            res.evicted_frame    = shadow_keys[pos];
            res.evicted_position = pos[8:0];
            for (int unsigned k = pos; k + 1 < shadow_count; k++)
                shadow_keys[k] = shadow_keys[k+1];
            shadow_count--;
        end
        return res;
    endfunction

    // Drive one input beat, at times with a random gap in front of it unless no_idle is set
    task automatic send_item(input sse_pkg::t_in_item item);
        if (!no_idle && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic push_item(input sse_pkg::t_in_item item);
        result_q.push_back(evict_or_insert(item));
        send_item(item);
    endtask

    // Let all results drain before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= '{index: idx, data: value};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == sse_pkg::CFG_THRESHOLD) shadow_thresh = value[9:0];
        else shadow_lcg = value;
    endtask

    // Random beats, table held near cap entries
    task automatic random_phase(input int n, input int unsigned cap);
        sse_pkg::t_in_item item;
        for (int k = 0; k < n; k++) begin
            item.frame_number = sse_pkg::FrameBits'($urandom() & 32'(FRAME_MAX));
            if (shadow_count >= cap || $urandom_range(0, 99) < 35) begin
                item.kind = KIND_EVICT;
            end else begin
                item.kind = KIND_INSERT;
                if ($urandom_range(0, 3) == 0)
                    item.frame_number = sse_pkg::FrameBits'($urandom_range(0, 63));
                else if (shadow_count > 0 && $urandom_range(0, 4) == 0)
                    item.frame_number = shadow_keys[$urandom_range(0, shadow_count - 1)];
            end
            push_item(item);
        end
    endtask

    // Output side stalls
    always @(posedge i_clk) begin
        i_out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end

    // Result checker
    always @(posedge i_clk) begin
        sse_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected beat", 32'(o_out_data.status), 0);
            end else begin
                want = result_q.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.evicted_frame !== want.evicted_frame)
                    report_mismatch("evicted_frame", 32'(o_out_data.evicted_frame),
                                    32'(want.evicted_frame));
                if (o_out_data.evicted_position !== want.evicted_position)
                    report_mismatch("evicted_position", 32'(o_out_data.evicted_position),
                                    32'(want.evicted_position));
            end
        end
    end

    typedef struct {
        logic      kind;
        logic [sse_pkg::FrameBits-1:0] frame;
        bit        typed;
        sse_pkg::t_out_item want;
    } t_dir_row;

    localparam int DirRows = 22;
    t_dir_row dir_tab [DirRows] = '{
        '{KIND_EVICT,  24'h000000, 1'b1, '{sse_pkg::ST_TOO_FEW,  24'h0, 9'd0}},
        '{KIND_INSERT, 24'h000000, 1'b1, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'h000000, 1'b1, '{sse_pkg::ST_PRESENT,  24'h0, 9'd0}},
        '{KIND_INSERT, 24'hffffff, 1'b1, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_EVICT,  24'hffffff, 1'b1, '{sse_pkg::ST_TOO_FEW,  24'h0, 9'd0}},
        '{KIND_INSERT, 24'h800000, 1'b1, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_EVICT,  24'h123456, 1'b1, '{sse_pkg::ST_EVICTED,  24'h800000, 9'd1}},
        '{KIND_INSERT, 24'h000010, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'h000020, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'h000030, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'h001000, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'hfffffe, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'hffffff, 1'b1, '{sse_pkg::ST_PRESENT,  24'h0, 9'd0}},
        '{KIND_EVICT,  24'hffffff, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}},
        '{KIND_INSERT, 24'h555555, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_INSERT, 24'haaaaaa, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_EVICT,  24'h000000, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}},
        '{KIND_EVICT,  24'h000000, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}},
        '{KIND_INSERT, 24'h000021, 1'b0, '{sse_pkg::ST_INSERTED, 24'h0, 9'd0}},
        '{KIND_EVICT,  24'h000000, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}},
        '{KIND_EVICT,  24'h000000, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}},
        '{KIND_EVICT,  24'h000000, 1'b0, '{sse_pkg::ST_EVICTED,  24'h0, 9'd0}}
    };

    // Main sequence
    initial begin
        sse_pkg::t_in_item  item;
        sse_pkg::t_out_item pred;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        err_count     = 0;
        no_idle       = 1'b0;
        shadow_count  = 0;
        shadow_lcg    = 32'd1;
        shadow_thresh = 10'd300;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings
        for (int r = 0; r < DirRows; r++) begin
            item = '{kind: dir_tab[r].kind, frame_number: dir_tab[r].frame};
            pred = evict_or_insert(item);
            result_q.push_back(dir_tab[r].typed ? dir_tab[r].want : pred);
            send_item(item);
        end

        // Random draw at every count, seed at its top
        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd3);
        write_reg(sse_pkg::CFG_SEED, 32'hffff_ffff);
        random_phase(25, 30);

        // Spacing score always
        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd512);
        write_reg(sse_pkg::CFG_SEED, 32'd0);
        random_phase(25, 20);

        // Threshold below three
        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd0);
        write_reg(sse_pkg::CFG_SEED, $urandom());
        random_phase(20, 25);

        // Threshold inside the working range, both methods mix
        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd12);
        write_reg(sse_pkg::CFG_SEED, $urandom());
        random_phase(20, 20);

        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd1023);
        random_phase(10, 10);

        // Long burst with no idling on either side
        drain();
        write_reg(sse_pkg::CFG_THRESHOLD, 32'd3);
        no_idle = 1'b1;
        random_phase(20, 40);
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
